>>> hdl/circular_first_fit_allocator_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef CIRCULAR_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define CIRCULAR_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CFFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cffa check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CFFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cffa check failed");

`endif

>>> hdl/cffa_pkg.sv
package cffa_pkg;

    // Arena geometry.
    localparam int ARENA_WORDS = 4096;
    localparam int WORD_BYTES  = 4;
    localparam int ADDR_W      = $clog2(ARENA_WORDS);

    // Field widths of the request and result beats.
    localparam int SIZE_W       = 14;
    localparam int FIELD_ADDR_W = 12;
    localparam int STATUS_W     = 2;

    // Width of the word count of a request, header included.
    localparam int MAX_NW = ((1 << SIZE_W) - 1 + 2 * WORD_BYTES - 1) / WORD_BYTES;
    localparam int NW_W   = $clog2(MAX_NW + 1);
    localparam int SUM_W  = $clog2((1 << SIZE_W) + 2 * WORD_BYTES);
    localparam int CMP_W  = ((NW_W > ADDR_W) ? NW_W : ADDR_W) + 1;

    localparam logic [ADDR_W-1:0] TOP_WORD = ADDR_W'(ARENA_WORDS - 1);

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // One header word: link to the next block and the busy flag.
    typedef struct packed {
        logic [ADDR_W-1:0] next;
        logic              busy;
    } link_t;

    // Access to the header memory for one cycle.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        link_t             wr_data;
    } mem_req_t;

    // Finished result handed to the output stage.
    typedef struct packed {
        logic                    valid;
        logic [STATUS_W-1:0]     status;
        logic [FIELD_ADDR_W-1:0] payload;
    } result_t;

endpackage

>>> hdl/circular_first_fit_allocator.sv
// Circular first-fit allocator over a 4096-word arena of block headers.
// Request beats arrive on the s_ channel: s_tuser selects allocate (0) or
// free (1); s_tdata carries the byte size and the payload word index to free.
// Every request returns exactly one result beat on the m_ channel with a
// status and, for a granted allocate, the payload word index.
// A free reads its header on accept and, if it is busy, writes it back free;
// a free with an out-of-range address goes straight to its result. An allocate
// reads each block header it visits, one more header per free header, and
// merges adjacent free blocks one at a time; a granted allocate then passes
// through the split step, which a failed allocate skips. The walk is bound by
// the single read port of the header memory, one header read each cycle.
// One request is in work at a time; s_tready rises again once the result has
// moved into the output register.
// After reset the block writes the initial arena image into the header
// memory, one word a cycle, with s_tready low until every word is written.
// A stall on m_tready holds the result register; one more request may be
// taken and worked meanwhile, and its result waits in the engine until the
// register empties.
module circular_first_fit_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // size_bytes[13:0], block_address[25:14], zero pad
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], payload_address[13:2], zero pad
);

    cffa_pkg::mem_req_t mem_req;
    cffa_pkg::link_t    rd_data;
    cffa_pkg::result_t  result;

    logic               res_ready;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    cffa_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    cffa_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_size   (s_tdata[13:0]),
        .in_addr   (s_tdata[25:14]),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .result    (result),
        .res_ready (res_ready)
    );

    // The output register takes a result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (result.valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid && res_ready)
        begin
            m_tdata_reg <= {2'b00, result.payload, result.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/cffa_mem.sv
module cffa_mem
(
    input  logic               clk,
    input  cffa_pkg::mem_req_t req,
    output cffa_pkg::link_t    rd_data
);

    cffa_pkg::link_t mem [cffa_pkg::ARENA_WORDS];
    cffa_pkg::link_t rd_data_reg;

    // One write port and one read port; the read returns the old entry on a collision.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/cffa_engine.sv
module cffa_engine
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_kind,
    input  logic [cffa_pkg::SIZE_W-1:0]            in_size,
    input  logic [cffa_pkg::FIELD_ADDR_W-1:0]      in_addr,
    output cffa_pkg::mem_req_t                     mem_req,
    input  cffa_pkg::link_t                        rd_data,
    output cffa_pkg::result_t                      result,
    input  logic                                   res_ready
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_WT_P    = 3'd2;
    localparam logic [2:0] S_WT_Q    = 3'd3;
    localparam logic [2:0] S_SPLIT   = 3'd4;
    localparam logic [2:0] S_FREE_WT = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    localparam int AW = cffa_pkg::ADDR_W;

    logic [2:0]                          state_reg,   state_next;
    logic [AW-1:0]                       clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]                       p_reg,       p_next;
    logic [AW-1:0]                       q_reg,       q_next;
    logic [AW-1:0]                       rover_reg,   rover_next;
    logic [AW-1:0]                       split_reg,   split_next;
    logic [cffa_pkg::NW_W-1:0]           nw_reg,      nw_next;
    logic                                wraps_reg,   wraps_next;
    logic [cffa_pkg::STATUS_W-1:0]       status_reg,  status_next;
    logic [cffa_pkg::FIELD_ADDR_W-1:0]   payload_reg, payload_next;

    logic [AW-1:0]                       hdr;
    logic                                bad_addr;
    logic [cffa_pkg::NW_W-1:0]           req_nw;
    logic [cffa_pkg::CMP_W-1:0]          split_w;
    logic                                fits;
    logic                                do_advance;
    logic [AW-1:0]                       adv_nxt;

    // Header index of a free request and its range check.
    assign hdr      = AW'(in_addr) - AW'(1);
    assign bad_addr = (in_addr == '0) || (hdr >= cffa_pkg::TOP_WORD);

    // Words needed: payload rounded up to words plus one header word.
    assign req_nw = cffa_pkg::NW_W'((cffa_pkg::SUM_W'(in_size)
                    + cffa_pkg::SUM_W'(2 * cffa_pkg::WORD_BYTES - 1))
                    / cffa_pkg::SUM_W'(cffa_pkg::WORD_BYTES));

    // Fit test of the merged free block at p that ends at q.
    assign split_w = cffa_pkg::CMP_W'(p_reg) + cffa_pkg::CMP_W'(nw_reg);
    assign fits    = (q_reg > p_reg)
                  && (cffa_pkg::CMP_W'(q_reg - p_reg) >= cffa_pkg::CMP_W'(nw_reg));

    // Link followed when the walk moves on from p.
    assign adv_nxt = (state_reg == S_WT_P) ? rd_data.next : q_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        rover_next   = rover_reg;
        split_next   = split_reg;
        nw_next      = nw_reg;
        wraps_next   = wraps_reg;
        status_next  = status_reg;
        payload_next = payload_reg;
        mem_req      = '0;
        do_advance   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Write the reset image: word zero free up to the top, top busy.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == '0)
                begin
                    mem_req.wr_data.next = cffa_pkg::TOP_WORD;
                end
                else if (clr_cnt_reg == cffa_pkg::TOP_WORD)
                begin
                    mem_req.wr_data.busy = 1'b1;
                end
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == cffa_pkg::TOP_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    payload_next = '0;
                    if (in_kind == cffa_pkg::KIND_FREE)
                    begin
                        if (bad_addr)
                        begin
                            status_next = cffa_pkg::STATUS_BAD_FREE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = hdr;
                            p_next          = hdr;
                            state_next      = S_FREE_WT;
                        end
                    end
                    else
                    begin
                        nw_next         = req_nw;
                        wraps_next      = 1'b0;
                        p_next          = rover_reg;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = rover_reg;
                        state_next      = S_WT_P;
                    end
                end
            end

            S_WT_P:
            begin
                // Header of p is here: a free block starts merging, a busy one is skipped.
                if (!rd_data.busy)
                begin
                    q_next          = rd_data.next;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_data.next;
                    state_next      = S_WT_Q;
                end
                else
                begin
                    do_advance = 1'b1;
                end
            end

            S_WT_Q:
            begin
                if (!rd_data.busy && (q_reg > p_reg))
                begin
                    // Absorb the free block at q. The read of its successor may
                    // collide with this write only when it points back to p, and
                    // then the merge stops on the index alone.
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = p_reg;
                    mem_req.wr_data.next = rd_data.next;
                    mem_req.wr_data.busy = 1'b0;
                    q_next               = rd_data.next;
                    mem_req.rd_en        = 1'b1;
                    mem_req.rd_addr      = rd_data.next;
                end
                else if (fits)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = p_reg;
                    mem_req.wr_data.next = split_w[AW-1:0];
                    mem_req.wr_data.busy = 1'b1;
                    split_next           = split_w[AW-1:0];
                    state_next           = S_SPLIT;
                end
                else
                begin
                    do_advance = 1'b1;
                end
            end

            S_SPLIT:
            begin
                // Remainder after the granted block becomes a free block.
                if (q_reg > split_reg)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = split_reg;
                    mem_req.wr_data.next = q_reg;
                    mem_req.wr_data.busy = 1'b0;
                end
                rover_next   = split_reg;
                status_next  = cffa_pkg::STATUS_OK;
                payload_next = cffa_pkg::FIELD_ADDR_W'(p_reg + AW'(1));
                state_next   = S_DONE;
            end

            S_FREE_WT:
            begin
                if (!rd_data.busy)
                begin
                    status_next = cffa_pkg::STATUS_BAD_FREE;
                end
                else
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = p_reg;
                    mem_req.wr_data.next = rd_data.next;
                    mem_req.wr_data.busy = 1'b0;
                    rover_next           = p_reg;
                    status_next          = cffa_pkg::STATUS_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next block, allowing one wrap from the top sentinel.
        if (do_advance)
        begin
            if (adv_nxt > p_reg)
            begin
                p_next          = adv_nxt;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = adv_nxt;
                state_next      = S_WT_P;
            end
            else if ((p_reg == cffa_pkg::TOP_WORD) && (adv_nxt == '0) && !wraps_reg)
            begin
                wraps_next      = 1'b1;
                p_next          = '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                state_next      = S_WT_P;
            end
            else
            begin
                status_next  = cffa_pkg::STATUS_NO_SPACE;
                payload_next = '0;
                state_next   = S_DONE;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            rover_reg   <= '0;
            wraps_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rover_reg   <= rover_next;
            wraps_reg   <= wraps_next;
        end
    end

    // Walk pointers and result payload.
    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        q_reg       <= q_next;
        split_reg   <= split_next;
        nw_reg      <= nw_next;
        status_reg  <= status_next;
        payload_reg <= payload_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign result.valid   = (state_reg == S_DONE);
    assign result.status  = status_reg;
    assign result.payload = payload_reg;

endmodule

>>> hdl/cffa_checker.sv
`include "circular_first_fit_allocator_macros.svh"

module cffa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [cffa_pkg::STATUS_W-1:0]     m_status;
    logic [cffa_pkg::FIELD_ADDR_W-1:0] m_payload;

    assign m_status  = m_tdata[1:0];
    assign m_payload = m_tdata[13:2];

    // Only the three defined status codes ever leave the block.
    `CFFA_ASSERT_SAME(a_status_code, m_tvalid, m_status <= cffa_pkg::STATUS_BAD_FREE)

    // Any failure carries a zero payload index.
    `CFFA_ASSERT_SAME(a_fail_zero, m_tvalid && (m_status != cffa_pkg::STATUS_OK), m_payload == '0)

    // One request at a time: the block is busy right after taking a beat.
    `CFFA_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)

    // A stalled result beat holds.
    `CFFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind circular_first_fit_allocator cffa_checker u_cffa_checker (.*);

>>> test/tb_circular_first_fit_allocator.sv
`timescale 1ns / 100ps

module tb_circular_first_fit_allocator;

    import cffa_pkg::*;

    // Idle phases, selected from the number of accepted requests.
    localparam int PHASE_FREE_RUN       = 0;
    localparam int PHASE_SENDER_IDLE    = 1;
    localparam int PHASE_RECEIVER_STALL = 2;
    localparam int PHASE_BOTH_IDLE      = 3;
    localparam int PHASE_LENGTH         = 150;

    localparam int RANDOM_REQUESTS = 1650;

    // Worst case per request: two wraps over up to 4096 headers, plus gaps and
    // stalls, times the request count, with a margin of several times that.
    localparam longint CYCLE_LIMIT = 64'd200_000_000;

    typedef struct packed {
        logic                    kind;
        logic [SIZE_W-1:0]       size;
        logic [FIELD_ADDR_W-1:0] addr;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [FIELD_ADDR_W-1:0] payload;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;    // size_bytes[13:0], block_address[25:14], zero pad
    logic        s_tuser = 1'b0;     // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // status[1:0], payload_address[13:2], zero pad

    // Shadow arena: one header per word, plus the search start pointer.
    logic [ADDR_W-1:0] hdr_next [0:ARENA_WORDS-1];
    logic              hdr_busy [0:ARENA_WORDS-1];
    int                search_start;

    request_t pending_requests[$];
    grant_t   expected_grants[$];
    int       allocated_payloads[$];
    int       released_payloads[$];
    request_t current_request;

    int     n_queued = 0;
    int     n_accepted = 0;
    int     mismatch_count = 0;
    longint cycle_count = 0;
    int     idle_phase;

    assign idle_phase = (n_accepted / PHASE_LENGTH) % 4;

    circular_first_fit_allocator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Work out the grant for one accepted request and update the shadow arena.
    task automatic predict_grant(input request_t req);
        int     nw;
        int     p;
        int     q;
        int     split;
        int     wraps;
        int     idx;
        bit     done;
        grant_t grant;
        begin
            grant.status  = STATUS_NO_SPACE;
            grant.payload = '0;
            if (req.kind == KIND_ALLOC)
            begin
                nw    = (int'(req.size) + 2 * WORD_BYTES - 1) / WORD_BYTES;
                p     = search_start;
                wraps = 0;
                done  = 1'b0;
                while (!done)
                begin
                    if (!hdr_busy[p])
                    begin
                        // Absorb following free blocks into this one.
                        while (1)
                        begin
                            q = hdr_next[p];
                            if (hdr_busy[q] || q <= p)
                                break;
                            hdr_next[p] = hdr_next[q];
                        end
                        q = hdr_next[p];
                        if (q > p && q - p >= nw)
                        begin
                            split = p + nw;
                            if (q > split)
                            begin
                                hdr_next[split] = ADDR_W'(q);
                                hdr_busy[split] = 1'b0;
                            end
                            hdr_next[p]   = ADDR_W'(split);
                            hdr_busy[p]   = 1'b1;
                            search_start  = split;
                            grant.status  = STATUS_OK;
                            grant.payload = FIELD_ADDR_W'(p + 1);
                            done          = 1'b1;
                        end
                    end
                    if (!done)
                    begin
                        q = p;
                        p = hdr_next[p];
                        if (p <= q)
                        begin
                            // Only the step from the top word to word zero is a wrap.
                            if (q != int'(TOP_WORD) || p != 0)
                                done = 1'b1;
                            else
                            begin
                                wraps++;
                                if (wraps > 1)
                                    done = 1'b1;
                            end
                        end
                    end
                end
                if (grant.status == STATUS_OK)
                    allocated_payloads.push_back(int'(grant.payload));
            end
            else
            begin
                if (req.addr == 0 || int'(req.addr) - 1 >= int'(TOP_WORD))
                    grant.status = STATUS_BAD_FREE;
                else if (!hdr_busy[int'(req.addr) - 1])
                    grant.status = STATUS_BAD_FREE;
                else
                begin
                    hdr_busy[int'(req.addr) - 1] = 1'b0;
                    search_start = int'(req.addr) - 1;
                    grant.status = STATUS_OK;
                    idx = -1;
                    foreach (allocated_payloads[i])
                        if (allocated_payloads[i] == int'(req.addr))
                            idx = i;
                    if (idx >= 0)
                        allocated_payloads.delete(idx);
                    released_payloads.push_back(int'(req.addr));
                    if (released_payloads.size() > 16)
                        void'(released_payloads.pop_front());
                end
            end
            expected_grants.push_back(grant);
        end
    endtask

    // Clock.
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Request driver: predicts each beat as it is accepted, then presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 32'd0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_grant(current_request);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() > 0 &&
                    !(idle_phase == PHASE_SENDER_IDLE && $urandom_range(99) < 62) &&
                    !(idle_phase == PHASE_BOTH_IDLE && $urandom_range(99) < 7))
                begin
                    current_request = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, current_request.addr, current_request.size};
                    s_tuser  <= current_request.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure by phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !((idle_phase == PHASE_RECEIVER_STALL && $urandom_range(99) < 62) ||
                          (idle_phase == PHASE_BOTH_IDLE && $urandom_range(99) < 7));
        end
    end

    // Result monitor: each accepted beat against the oldest expected grant.
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: result beat with no request outstanding: status %0d payload %0d",
                         $time, m_tdata[1:0], m_tdata[13:2]);
                mismatch_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (m_tdata[1:0] !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[13:2] !== want.payload)
                begin
                    $display("%0t: payload address mismatch: expected %0d, actual %0d",
                             $time, want.payload, m_tdata[13:2]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed requests, then random batches fed on demand.
    initial
    begin
        request_t req;
        int       roll;
        int       free_bias;
        int       n_random;

        // Shadow arena after reset: word zero free up to the top sentinel.
        for (int i = 0; i < ARENA_WORDS; i++)
        begin
            hdr_next[i] = '0;
            hdr_busy[i] = 1'b0;
        end
        hdr_next[0]        = TOP_WORD;
        hdr_busy[TOP_WORD] = 1'b1;
        search_start       = 0;

        // Directed part: largest requests, whole-arena grant, zero-byte blocks,
        // exact fits, double and out-of-range frees, merges on the walk.
        pending_requests.push_back('{KIND_ALLOC, 14'd16383, 12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd16377, 12'd4095});
        pending_requests.push_back('{KIND_ALLOC, 14'd16376, 12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd0,     12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd1});
        pending_requests.push_back('{KIND_FREE,  14'd16383, 12'd1});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd4095});
        pending_requests.push_back('{KIND_ALLOC, 14'd0,     12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd1,     12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd4,     12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd5,     12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd2});
        pending_requests.push_back('{KIND_ALLOC, 14'd3,     12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd1});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd2});
        pending_requests.push_back('{KIND_ALLOC, 14'd8,     12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd4});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd6});
        pending_requests.push_back('{KIND_ALLOC, 14'd16,    12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd16383, 12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd9});
        pending_requests.push_back('{KIND_ALLOC, 14'd12,    12'd0});
        pending_requests.push_back('{KIND_ALLOC, 14'd8192,  12'd0});
        pending_requests.push_back('{KIND_FREE,  14'd0,     12'd4094});
        n_queued = pending_requests.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Random part, generated a few beats ahead so frees can target live blocks.
        n_random = 0;
        while (n_random < RANDOM_REQUESTS)
        begin
            while (pending_requests.size() > 2)
                @(posedge clk);
            repeat (8)
            begin
                roll      = $urandom_range(99);
                free_bias = (allocated_payloads.size() > 120) ? 60 : 40;
                req.size  = SIZE_W'($urandom);
                req.addr  = FIELD_ADDR_W'($urandom);
                if (roll < free_bias)
                begin
                    req.kind = KIND_FREE;
                    roll = $urandom_range(99);
                    if (roll < 75 && allocated_payloads.size() > 0)
                        req.addr = FIELD_ADDR_W'(allocated_payloads[
                                       $urandom_range(allocated_payloads.size() - 1)]);
                    else if (roll >= 87 && roll < 97 && released_payloads.size() > 0)
                        req.addr = FIELD_ADDR_W'(released_payloads[
                                       $urandom_range(released_payloads.size() - 1)]);
                    else if (roll >= 97)
                        req.addr = '0;
                end
                else
                begin
                    req.kind = KIND_ALLOC;
                    roll = $urandom_range(99);
                    if (roll < 70)
                        req.size = SIZE_W'($urandom_range(64));
                    else if (roll < 90)
                        req.size = SIZE_W'($urandom_range(1024));
                    else if (roll < 98)
                        req.size = SIZE_W'($urandom_range(16383));
                    else if (roll < 99)
                        req.size = SIZE_W'(16383);
                    else
                        req.size = '0;
                end
                pending_requests.push_back(req);
                n_queued++;
                n_random++;
            end
        end

        // Drain: every request accepted, every grant seen, then a short settle.
        while (n_accepted < n_queued)
            @(posedge clk);
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cffa_pkg.sv
hdl/cffa_mem.sv
hdl/cffa_engine.sv
hdl/circular_first_fit_allocator.sv
hdl/cffa_checker.sv
test/tb_circular_first_fit_allocator.sv
